>>> rtl/core/sti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg
// Widths and shared types for the symmetric tensor invariants pipeline.
// ----------------------------------------------------------------------------
package sti_pkg;
  localparam int CompBits   = 16;
  localparam int TraceBits  = CompBits + 2;
  localparam int SecondBits = 2 * CompBits + 1;
  localparam int DetBits    = 3 * CompBits + 1;
  localparam int RootBits   = CompBits + 1;
  // sum of squares: max 9 * 2^30 fits in 34 bits
  localparam int SqBits     = 2 * CompBits + 2;
  localparam int ProdBits   = 2 * CompBits;
  // root stages, two root bits resolved per stage
  localparam int RootSteps  = RootBits;
  localparam int RootPerStg = 2;
  localparam int RootStages = (RootSteps + RootPerStg - 1) / RootPerStg;
  // ceil(2^TraceBits / 3): x * Recip3 >> TraceBits is floor(x/3) for x < 2^17
  localparam int Recip3     = ((1 << TraceBits) + 2) / 3;

  typedef logic signed [CompBits-1:0]   comp_t;
  typedef logic signed [ProdBits:0]     prod_t;
  typedef logic signed [DetBits-1:0]    det_t;
  typedef logic        [SqBits-1:0]     sq_t;
  typedef logic        [RootBits-1:0]   root_t;

  // square-root working state for one radicand
  typedef struct packed {
    sq_t   rem;
    root_t root;
  } sqrt_st_t;
endpackage

>>> rtl/core/symmetric_tensor_invariants_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_tensor_invariants_core
// Trace, second invariant, determinant, magnitude and deviator of a
// symmetric 3x3 tensor in signed Q8.8, fully pipelined.
// ----------------------------------------------------------------------------
// channel | ports                          | role
// in      | in_valid/in_stall, comp_*      | tensor request
// out     | out_valid/out_stall, results   | invariant request
//
// One request per cycle unless stalled; 9 root stages after the front stages.
// Reset clears only valid bits; payload registers are unreset.
// A stall with a result waiting freezes the whole pipe; in_stall follows it.
// ----------------------------------------------------------------------------
module symmetric_tensor_invariants_core
  import sti_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  comp_t                        in_comp_xx,
  input  comp_t                        in_comp_yy,
  input  comp_t                        in_comp_zz,
  input  comp_t                        in_comp_yz,
  input  comp_t                        in_comp_xz,
  input  comp_t                        in_comp_xy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [TraceBits-1:0]  out_trace_sum,
  output logic signed [SecondBits-1:0] out_second_inv,
  output det_t                         out_det_value,
  output root_t                        out_magnitude_out,
  output root_t                        out_deviator_out
);
  logic en;
  logic p_v;
  logic signed [TraceBits-1:0]  p_tr;
  logic signed [SecondBits-1:0] p_sec;
  det_t p_det;
  sq_t  p_sq, p_dev;

  logic v_r [RootStages];
  logic signed [TraceBits-1:0]  tr_r  [RootStages];
  logic signed [SecondBits-1:0] sec_r [RootStages];
  det_t det_r [RootStages];

  // stall only when a result waits at the output
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  sti_poly u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid),
    .a(in_comp_xx), .b(in_comp_yy), .c(in_comp_zz),
    .d(in_comp_yz), .e(in_comp_xz), .f(in_comp_xy),
    .o_v(p_v), .o_tr(p_tr), .o_sec(p_sec), .o_det(p_det),
    .o_sq(p_sq), .o_dev(p_dev)
  );

  sti_sqrt u_mag (.clk(clk), .en(en), .rad(p_sq),  .root(out_magnitude_out));
  sti_sqrt u_dev (.clk(clk), .en(en), .rad(p_dev), .root(out_deviator_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RootStages; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= p_v;
      for (int i = 1; i < RootStages; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr_r[0] <= p_tr; sec_r[0] <= p_sec; det_r[0] <= p_det;
      for (int i = 1; i < RootStages; i++) begin
        tr_r[i] <= tr_r[i-1]; sec_r[i] <= sec_r[i-1]; det_r[i] <= det_r[i-1];
      end
    end
  end

  assign out_valid      = v_r[RootStages-1];
  assign out_trace_sum  = tr_r[RootStages-1];
  assign out_second_inv = sec_r[RootStages-1];
  assign out_det_value  = det_r[RootStages-1];
endmodule

>>> rtl/core/sti_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_poly
// Front stages: products, trace, second invariant, determinant and the
// two square-root radicands. Four register stages, stall held in place.
// ----------------------------------------------------------------------------
module sti_poly
  import sti_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_v,
  input  comp_t                        a, b, c, d, e, f,
  output logic                         o_v,
  output logic signed [TraceBits-1:0]  o_tr,
  output logic signed [SecondBits-1:0] o_sec,
  output det_t                         o_det,
  output sq_t                          o_sq,
  output sq_t                          o_dev
);
  // stage 1: inputs
  logic  v1_r;
  comp_t a_r, b_r, c_r, d_r, e_r, f_r;
  // stage 2: pairwise products
  logic v2_r;
  prod_t pbc_r, pdd_r, pfc_r, pde_r, pfd_r, pbe_r, paa_r, pbb_r, pcc_r;
  prod_t pee_r, pff_r, pab_r, pac_r;
  comp_t a2_r, e2_r, f2_r;
  logic signed [TraceBits-1:0] tr2_r;
  // stage 3: minors times component, |trace| split as 3q + r
  logic v3_r;
  det_t  m1_r, m2_r, m3_r;
  logic signed [SecondBits-1:0] sec3_r;
  sq_t   sq3_r;
  logic  [TraceBits-1:0] q3_r;
  logic  [1:0]           r3_r;
  logic signed [TraceBits-1:0] tr3_r;
  // stage 4: outputs
  logic v4_r;

  logic [TraceBits-1:0]   tr_abs;
  logic [2*TraceBits-1:0] q_mul;
  logic [TraceBits-1:0]   q_c;
  logic [TraceBits-1:0]   r_c;
  logic [2*TraceBits-1:0] q_sq;
  sq_t                    div3_c;

  always_comb begin
    // floor(|tr|/3) by reciprocal multiply
    tr_abs = tr2_r[TraceBits-1] ? TraceBits'(-tr2_r) : TraceBits'(tr2_r);
    q_mul  = {{TraceBits{1'b0}}, tr_abs} * (2*TraceBits)'(Recip3);
    q_c    = q_mul[2*TraceBits-1:TraceBits];
    r_c    = tr_abs - q_c * TraceBits'(3);
    // floor(tr^2/3) = 3q^2 + 2qr + floor(r^2/3)
    q_sq   = {{TraceBits{1'b0}}, q3_r} * {{TraceBits{1'b0}}, q3_r};
    div3_c = SqBits'(q_sq) + SqBits'({q_sq, 1'b0})
           + (r3_r[1] ? SqBits'({q3_r, 2'b00}) : '0)
           + (r3_r[0] ? SqBits'({q3_r, 1'b0}) : '0)
           + SqBits'(r3_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a; b_r <= b; c_r <= c; d_r <= d; e_r <= e; f_r <= f;

      pbc_r <= prod_t'(b_r) * prod_t'(c_r); pdd_r <= prod_t'(d_r) * prod_t'(d_r);
      pfc_r <= prod_t'(f_r) * prod_t'(c_r); pde_r <= prod_t'(d_r) * prod_t'(e_r);
      pfd_r <= prod_t'(f_r) * prod_t'(d_r); pbe_r <= prod_t'(b_r) * prod_t'(e_r);
      paa_r <= prod_t'(a_r) * prod_t'(a_r); pbb_r <= prod_t'(b_r) * prod_t'(b_r);
      pcc_r <= prod_t'(c_r) * prod_t'(c_r); pee_r <= prod_t'(e_r) * prod_t'(e_r);
      pff_r <= prod_t'(f_r) * prod_t'(f_r); pab_r <= prod_t'(a_r) * prod_t'(b_r);
      pac_r <= prod_t'(a_r) * prod_t'(c_r);
      a2_r <= a_r; e2_r <= e_r; f2_r <= f_r;
      tr2_r <= TraceBits'(a_r) + TraceBits'(b_r) + TraceBits'(c_r);

      m1_r <= det_t'(a2_r) * det_t'(pbc_r - pdd_r);
      m2_r <= det_t'(f2_r) * det_t'(pfc_r - pde_r);
      m3_r <= det_t'(e2_r) * det_t'(pfd_r - pbe_r);
      sec3_r <= SecondBits'(pab_r) + SecondBits'(pac_r) + SecondBits'(pbc_r)
              - SecondBits'(pff_r) - SecondBits'(pee_r) - SecondBits'(pdd_r);
      sq3_r <= SqBits'(paa_r) + SqBits'(pbb_r) + SqBits'(pcc_r)
             + ((SqBits'(pdd_r) + SqBits'(pee_r) + SqBits'(pff_r)) << 1);
      q3_r  <= q_c;
      r3_r  <= r_c[1:0];
      tr3_r <= tr2_r;

      o_tr  <= tr3_r;
      o_sec <= sec3_r;
      o_det <= m1_r - m2_r + m3_r;
      o_sq  <= sq3_r;
      o_dev <= (sq3_r > div3_c) ? sq3_r - div3_c : '0;
    end
  end

  assign o_v = v4_r;
endmodule

>>> rtl/core/sti_sqrt_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_sqrt_stage
// Two steps of the digit-by-digit square root, combinational.
// ----------------------------------------------------------------------------
module sti_sqrt_stage
  import sti_pkg::*;
(
  input  sq_t      rad,
  input  int       first_step,
  input  sqrt_st_t st_in,
  output sqrt_st_t st_out
);
  logic [SqBits+1:0] trial;
  logic [SqBits+1:0] rem_w;
  root_t             rt;
  int                k;

  // restoring root: bring down a radicand bit pair, try (4r+1)
  always_comb begin
    rem_w = {2'b00, st_in.rem};
    rt    = st_in.root;
    for (int s = 0; s < RootPerStg; s++) begin
      k = first_step + s;
      if (k < RootSteps) begin
        rem_w = {rem_w[SqBits-1:0], rad[2*(RootSteps-1-k)+1 -: 2]};
        trial = (SqBits+2)'({rt, 2'b01});
        rt = {rt[RootBits-2:0], 1'b0};
        if (rem_w >= trial) begin
          rem_w = rem_w - trial;
          rt[0] = 1'b1;
        end
      end else begin
        trial = '0;
      end
    end
    st_out.rem  = rem_w[SqBits-1:0];
    st_out.root = rt;
  end
endmodule

>>> rtl/core/sti_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_sqrt
// Pipelined floor square root, two root bits per register stage.
// ----------------------------------------------------------------------------
module sti_sqrt
  import sti_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  sq_t   rad,
  output root_t root
);
  sq_t      rad_r [RootStages];
  sqrt_st_t st_r  [RootStages];
  sqrt_st_t st_c  [RootStages];

  for (genvar g = 0; g < RootStages; g++) begin : g_stg
    sqrt_st_t st_src;
    sq_t      rad_src;
    if (g == 0) begin : g_first
      assign st_src  = '0;
      assign rad_src = rad;
    end else begin : g_rest
      assign st_src  = st_r[g-1];
      assign rad_src = rad_r[g-1];
    end
    sti_sqrt_stage u_stg (
      .rad(rad_src), .first_step(g * RootPerStg), .st_in(st_src), .st_out(st_c[g])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g]  <= st_c[g];
        rad_r[g] <= rad_src;
      end
    end
  end

  assign root = st_r[RootStages-1].root;
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for symmetric_tensor_invariants_core: directed and random
// tensors are driven through a valid/stall handshake, and each result is
// checked against a predictor with exact integer arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  import sti_pkg::*;

  localparam int PipeLatency = 13;
  localparam longint CycleLimit = 400000;

  typedef struct {
    logic signed [TraceBits-1:0]  trace_sum;
    logic signed [SecondBits-1:0] second_inv;
    det_t                         det_value;
    root_t                        magnitude;
    root_t                        deviator;
  } invariants_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  comp_t in_comp_xx = '0, in_comp_yy = '0, in_comp_zz = '0;
  comp_t in_comp_yz = '0, in_comp_xz = '0, in_comp_xy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [TraceBits-1:0]  out_trace_sum;
  logic signed [SecondBits-1:0] out_second_inv;
  det_t  out_det_value;
  root_t out_magnitude_out;
  root_t out_deviator_out;

  invariants_t expected_q[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  tensors_sent = 0;
  longint cycle_count = 0;
  bit  hold_off = 1'b0;     // receiver parks for a long stretch
  bit  no_gaps = 1'b0;
  int  stall_left = 0;

  symmetric_tensor_invariants_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic invariants_t tensor_invariants(comp_t xx, yy, zz, yz, xz, xy);
    longint a, b, c, d, e, f, tr, sec, det, sq, tr2, rad;
    invariants_t r;
    a = xx; b = yy; c = zz; d = yz; e = xz; f = xy;
    tr  = a + b + c;
    sec = a*b + a*c + b*c - f*f - e*e - d*d;
    det = a*(b*c - d*d) - f*(f*c - d*e) + e*(f*d - b*e);
    sq  = a*a + b*b + c*c + 2*(d*d + e*e + f*f);
    tr2 = (tr*tr) / 3;
    rad = (sq > tr2) ? sq - tr2 : 0;
    r.trace_sum  = tr[TraceBits-1:0];
    r.second_inv = sec[SecondBits-1:0];
    r.det_value  = det[DetBits-1:0];
    r.magnitude  = root_t'(isqrt(sq));
    r.deviator   = root_t'(isqrt(rad));
    return r;
  endfunction

  // receiver stall: short random gaps, now and then a long one, a hold-off, or none with no_gaps
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (no_gaps) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(8, 40);
    end else begin
      out_stall <= ($urandom_range(0, 9) < 2);
    end
  end

  // result checker
  always @(posedge clk) begin
    invariants_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result trace=%0d", $time, out_trace_sum);
        mismatches++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_trace_sum !== exp_r.trace_sum) begin
          $display("%0t trace: expected %0d got %0d", $time, exp_r.trace_sum, out_trace_sum);
          mismatches++;
        end
        if (out_second_inv !== exp_r.second_inv) begin
          $display("%0t second_inv: expected %0d got %0d", $time, exp_r.second_inv,
                   out_second_inv);
          mismatches++;
        end
        if (out_det_value !== exp_r.det_value) begin
          $display("%0t det: expected %0d got %0d", $time, exp_r.det_value, out_det_value);
          mismatches++;
        end
        if (out_magnitude_out !== exp_r.magnitude) begin
          $display("%0t magnitude: expected %0d got %0d", $time, exp_r.magnitude,
                   out_magnitude_out);
          mismatches++;
        end
        if (out_deviator_out !== exp_r.deviator) begin
          $display("%0t deviator: expected %0d got %0d", $time, exp_r.deviator,
                   out_deviator_out);
          mismatches++;
        end
      end
    end
  end

  // one request; in_valid stays high if another follows with no gap
  task automatic send_tensor(comp_t xx, yy, zz, yz, xz, xy, bit gaps);
    int gap;
    in_valid   <= 1'b1;
    in_comp_xx <= xx; in_comp_yy <= yy; in_comp_zz <= zz;
    in_comp_yz <= yz; in_comp_xz <= xz; in_comp_xy <= xy;
    do @(posedge clk); while (in_stall);
    expected_q.insert(expected_q.size(), tensor_invariants(xx, yy, zz, yz, xz, xy));
    tensors_sent++;
    if (gaps) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'(16'h8000);
      1: return comp_t'(16'h7fff);
      2: return comp_t'($urandom_range(0, 512) - 256);
      default: return comp_t'($urandom());
    endcase
  endfunction

  task automatic test_extremes();
    comp_t mn, mx;
    mn = comp_t'(16'h8000);
    mx = comp_t'(16'h7fff);
    send_tensor(0, 0, 0, 0, 0, 0, 0);
    send_tensor(mn, mn, mn, mn, mn, mn, 0);
    send_tensor(mx, mx, mx, mx, mx, mx, 0);
    send_tensor(mn, mn, mn, 0, 0, 0, 0);
    send_tensor(mx, mx, mx, 0, 0, 0, 0);
    send_tensor(0, 0, 0, mn, mn, mn, 0);
    send_tensor(mn, mx, mn, mx, mn, mx, 0);
    send_tensor(mx, mn, mx, mn, mx, mn, 0);
    send_tensor(-1, -1, -1, -1, -1, -1, 0);
    send_tensor(256, 256, 256, 0, 0, 0, 0);   // identity
    send_tensor(256, -256, 0, 0, 0, 0, 0);    // traceless
    send_tensor(0, 0, 0, 256, 0, 0, 0);
    send_tensor(0, 0, 0, 0, 256, 0, 0);
    send_tensor(0, 0, 0, 0, 0, 256, 0);
    send_tensor(mn, 0, 0, 0, 0, 0, 0);
    send_tensor(1, 2, 3, 4, 5, 6, 0);
    end_burst();
    wait_drained();
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_tensor(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), 1);
    end_burst();
  endtask

  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    repeat (count)
      send_tensor(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                  rand_comp(), 0);
    end_burst();
    no_gaps = 1'b0;
  endtask

  // receiver parks while the sender keeps offering, so in_stall must rise
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (40)
        send_tensor(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                    rand_comp(), 0);
    join
    end_burst();
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random(900);
    test_backpressure();
    test_back_to_back(200);
    wait_drained();           // sender pauses until every result is in
    test_random(700);
    wait_drained();
    repeat (PipeLatency + 5) @(posedge clk);
    $display("Sent %0d tensors, checked %0d results: extremes, random, back-to-back,",
             tensors_sent, results_seen);
    $display("and a long output hold-off; %0d mismatches", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
